>>> rtl/viewport_fit_calculator_defines.svh
// Assertion macros used by the viewport fit calculator top-level RTL.
// No dependencies.
`ifndef VIEWPORT_FIT_CALCULATOR_DEFINES_SVH
`define VIEWPORT_FIT_CALCULATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked during reset too.
`define VFC_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/vfc_pkg.sv
// Types and constants for the viewport fit calculator.
// No dependencies.
package vfc_pkg;

   localparam int DIM_W = 14;
   localparam int OFS_W = DIM_W - 1;
   localparam int CMD_W = 2;

   localparam logic [CMD_W-1:0] CMD_FILL    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ASPECT  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_INTEGER = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [DIM_W-1:0] src_width;
      logic [DIM_W-1:0] src_height;
      logic [DIM_W-1:0] dst_width;
      logic [DIM_W-1:0] dst_height;
   } req_type;

   typedef struct packed {
      logic [OFS_W-1:0] rect_x;
      logic [OFS_W-1:0] rect_y;
      logic [DIM_W-1:0] rect_w;
      logic [DIM_W-1:0] rect_h;
      logic             size_error;
   } rsp_type;

   // Per-request sideband that rides alongside the dividers.
   typedef struct packed {
      logic             fit_aspect;
      logic             fit_integer;
      logic             err;
      logic [DIM_W-1:0] sw;
      logic [DIM_W-1:0] sh;
      logic [DIM_W-1:0] dw;
      logic [DIM_W-1:0] dh;
   } side_type;

endpackage

>>> rtl/vfc_div.sv
// Pipelined restoring divider, one quotient bit per stage, quotient limited
// to DIM_BITS bits with an overflow flag. Depends on vfc_pkg.
module vfc_div import vfc_pkg::*; #(
   parameter int DIM_BITS = DIM_W
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [2*DIM_BITS-1:0]   num,
   input  logic [DIM_BITS-1:0]     den,
   output logic [DIM_BITS-1:0]     quot,
   output logic                    ovf
);

   localparam int NW = 2 * DIM_BITS;

   logic [NW-1:0]       rem_ff  [0:DIM_BITS];
   logic [DIM_BITS-1:0] den_ff  [0:DIM_BITS];
   logic [DIM_BITS-1:0] q_ff    [0:DIM_BITS];
   logic                ovf_ff  [0:DIM_BITS];

   // Entry stage: quotient overflows when num >= den * 2^DIM_BITS.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num;
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         ovf_ff[0] <= (num >= {den, {DIM_BITS{1'b0}}});
      end
   end

   for (genvar i = 1; i <= DIM_BITS; i++) begin : g_stage
      localparam int B = DIM_BITS - i;
      logic [NW-1:0]       shd;
      logic                take;
      logic [DIM_BITS-1:0] q_in;

      assign shd  = NW'({den_ff[i-1]} << B);
      assign take = rem_ff[i-1] >= shd;

      always_comb begin
         q_in    = q_ff[i-1];
         q_in[B] = take;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= take ? rem_ff[i-1] - shd : rem_ff[i-1];
            den_ff[i] <= den_ff[i-1];
            q_ff[i]   <= q_in;
            ovf_ff[i] <= ovf_ff[i-1];
         end
      end
   end

   assign quot = q_ff[DIM_BITS];
   assign ovf  = ovf_ff[DIM_BITS];

endmodule

>>> rtl/viewport_fit_calculator.sv
// Viewport fit calculator: letterbox / pillarbox / integer scale placement.
// A request passes through decode, the divider pipelines, select, size and output
// registers; one request per cycle sustained while the output is not stalled.
// The whole pipeline holds while a response waits under stall.
// Synchronous active-high reset clears all valid bits; data regs unreset.
// Depends on vfc_pkg, vfc_div and viewport_fit_calculator_defines.svh.
`include "viewport_fit_calculator_defines.svh"
module viewport_fit_calculator import vfc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int NW = 2 * DIM_W;

   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // Stage 0: decode and products.
   logic          v0_ff;
   side_type      s0_ff;
   logic [NW-1:0] pa_ff, pb_ff;
   side_type      s0_in;
   logic          fit1, fit2;

   assign fit1 = req_data.command == CMD_ASPECT;
   assign fit2 = req_data.command == CMD_INTEGER;

   always_comb begin
      s0_in.fit_aspect  = fit1;
      s0_in.fit_integer = fit2;
      s0_in.err         = (fit1 || fit2) &&
                          (req_data.src_width == '0 || req_data.src_height == '0);
      s0_in.sw          = req_data.src_width;
      s0_in.sh          = req_data.src_height;
      s0_in.dw          = req_data.dst_width;
      s0_in.dh          = req_data.dst_height;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff <= s0_in;
         pa_ff <= s0_in.fit_aspect ? req_data.dst_width * req_data.src_height
                                   : NW'(req_data.dst_width);
         pb_ff <= s0_in.fit_aspect ? req_data.dst_height * req_data.src_width
                                   : NW'(req_data.dst_height);
      end
   end

   // Divider lanes: A = numerator over sw, B = numerator over sh.
   logic [DIM_W-1:0] qa, qb;
   logic             oa, ob;

   vfc_div #(.DIM_BITS(DIM_W)) u_div_a (
      .clock(clock), .en(en), .num(pa_ff), .den(s0_ff.sw), .quot(qa), .ovf(oa)
   );
   vfc_div #(.DIM_BITS(DIM_W)) u_div_b (
      .clock(clock), .en(en), .num(pb_ff), .den(s0_ff.sh), .quot(qb), .ovf(ob)
   );

   // Sideband and valid follow the divider depth.
   logic     vd_ff [0:DIM_W];
   side_type sd_ff [0:DIM_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DIM_W; i++) vd_ff[i] <= 1'b0;
      end else if (en) begin
         vd_ff[0] <= v0_ff;
         for (int i = 1; i <= DIM_W; i++) vd_ff[i] <= vd_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff[0] <= s0_ff;
         for (int i = 1; i <= DIM_W; i++) sd_ff[i] <= sd_ff[i-1];
      end
   end

   // Select stage: letterbox vs pillarbox, or the integer scale.
   side_type         sd;
   logic             too_tall;
   logic             vs_ff;
   side_type         ss_ff;
   logic [DIM_W-1:0] ws_ff, hs_ff, k_ff;

   assign sd       = sd_ff[DIM_W];
   assign too_tall = oa || (qa > sd.dh);

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff <= 1'b0;
      end else if (en) begin
         vs_ff <= vd_ff[DIM_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ss_ff <= sd;
         ws_ff <= too_tall ? qb : sd.dw;
         hs_ff <= too_tall ? sd.dh : qa;
         k_ff  <= (qa < qb) ? qa : qb;
      end
   end

   // Size stage.
   logic             vm_ff;
   side_type         sm_ff;
   logic [DIM_W-1:0] wm_ff, hm_ff;
   logic [NW-1:0]    wk, hk;

   assign wk = ss_ff.sw * k_ff;
   assign hk = ss_ff.sh * k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
      end else if (en) begin
         vm_ff <= vs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sm_ff <= ss_ff;
         priority if (ss_ff.err) begin
            wm_ff <= '0;
            hm_ff <= '0;
         end else if (ss_ff.fit_integer) begin
            wm_ff <= wk[DIM_W-1:0];
            hm_ff <= hk[DIM_W-1:0];
         end else if (ss_ff.fit_aspect) begin
            wm_ff <= ws_ff;
            hm_ff <= hs_ff;
         end else begin
            wm_ff <= ss_ff.dw;
            hm_ff <= ss_ff.dh;
         end
      end
   end

   // Output stage: even floor and centering.
   logic             fit_ok;
   logic [DIM_W-1:0] we, he, dx, dy;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   assign fit_ok = (sm_ff.fit_aspect || sm_ff.fit_integer) && !sm_ff.err;
   assign we     = fit_ok ? {wm_ff[DIM_W-1:1], 1'b0} : wm_ff;
   assign he     = fit_ok ? {hm_ff[DIM_W-1:1], 1'b0} : hm_ff;
   assign dx     = sm_ff.dw - we;
   assign dy     = sm_ff.dh - he;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff.rect_x     <= fit_ok ? dx[DIM_W-1:1] : '0;
         rsp_ff.rect_y     <= fit_ok ? dy[DIM_W-1:1] : '0;
         rsp_ff.rect_w     <= we;
         rsp_ff.rect_h     <= he;
         rsp_ff.size_error <= sm_ff.err;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `VFC_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && rsp_data.size_error, rsp_data.rect_w == '0 && rsp_data.rect_h == '0 && rsp_data.rect_x == '0 && rsp_data.rect_y == '0, "error response with nonzero rectangle")
   `VFC_ASSERT_NOW(a_sel_fits, clock, reset, vs_ff && ss_ff.fit_aspect && !ss_ff.err, hs_ff <= ss_ff.dh && ws_ff <= ss_ff.dw, "aspect fit exceeds target")
   `VFC_ASSERT_NOW(a_hold, clock, reset, rsp_valid && rsp_stall, req_stall, "pipeline advanced under output stall")
   `VFC_ASSERT_NEXT(a_reset, clock, reset, !rsp_valid && !vm_ff && !vs_ff, "valid survived reset")

endmodule

>>> tb/sv/tb_top.sv
// Testbench for viewport_fit_calculator: directed and random placement requests,
// results predicted in the scoreboard and compared in order.
// Depends on vfc_pkg and the viewport_fit_calculator RTL.
module tb_top;
   import vfc_pkg::*;

   class placement_scoreboard;
      rsp_type pending[$];
      int errors = 0;

      function rsp_type place(req_type r);
         rsp_type o;
         logic [31:0] w, h, kx, ky, k;
         o = '0;
         w = 0;
         h = 0;
         if (r.command == CMD_ASPECT || r.command == CMD_INTEGER) begin
            if (r.src_width == 0 || r.src_height == 0) begin
               o.size_error = 1'b1;
               return o;
            end
            if (r.command == CMD_ASPECT) begin
               w = r.dst_width;
               h = (32'(r.dst_width) * r.src_height) / r.src_width;
               if (h > r.dst_height) begin
                  h = r.dst_height;
                  w = (32'(r.dst_height) * r.src_width) / r.src_height;
               end
            end else begin
               kx = r.dst_width / r.src_width;
               ky = r.dst_height / r.src_height;
               k = (kx < ky) ? kx : ky;
               w = r.src_width * k;
               h = r.src_height * k;
            end
            w[0] = 1'b0;
            h[0] = 1'b0;
            o.rect_x = OFS_W'((r.dst_width - w) >> 1);
            o.rect_y = OFS_W'((r.dst_height - h) >> 1);
            o.rect_w = DIM_W'(w);
            o.rect_h = DIM_W'(h);
         end else begin
            // fill, and the unused mode
            o.rect_w = r.dst_width;
            o.rect_h = r.dst_height;
         end
         return o;
      endfunction

      function void note_request(req_type r);
         pending.push_back(place(r));
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %p", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.rect_x !== e.rect_x || a.rect_y !== e.rect_y || a.rect_w !== e.rect_w
             || a.rect_h !== e.rect_h || a.size_error !== e.size_error) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, a);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_type rsp_data;
   placement_scoreboard board = new();
   int cycles = 0;
   bit hold_off = 0;
   bit random_stall = 0;

   viewport_fit_calculator dut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 200000) begin
         $display("[viewport_fit_calculator] ERROR");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);

   // receiver stall pattern
   initial begin
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1;
            repeat (150) @(posedge clock);
            rsp_stall <= 0;
            hold_off = 0;
         end else if (random_stall) begin
            n = $urandom_range(0, 8);
            rsp_stall <= (n != 0);
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   task automatic send(req_type r, bit gaps);
      int n;
      n = gaps ? $urandom_range(0, 8) : 0;
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_data <= r;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
   endtask

   function automatic logic [DIM_W-1:0] rand_dim();
      case ($urandom_range(0, 4))
         0: return DIM_W'($urandom_range(0, 16));
         1: return DIM_W'($urandom_range(0, 255));
         2: return DIM_W'($urandom_range(16300, 16383));
         default: return DIM_W'($urandom);
      endcase
   endfunction

   initial begin
      req_type r;
      logic [DIM_W-1:0] edges[4];
      edges = '{14'd0, 14'd1, 14'd16383, 14'd16382};
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (edges[i]) begin
         r = '{CMD_ASPECT, edges[i], edges[3 - i], 14'd16383, edges[i]};
         send(r, 0);
      end
      send('{CMD_FILL, 14'd0, 14'd0, 14'd1920, 14'd1081}, 0);
      send('{2'd3, 14'd5, 14'd3, 14'd641, 14'd479}, 0);
      send('{CMD_ASPECT, 14'd1920, 14'd1080, 14'd1024, 14'd768}, 0);
      send('{CMD_ASPECT, 14'd640, 14'd480, 14'd1920, 14'd1080}, 0);
      send('{CMD_ASPECT, 14'd0, 14'd480, 14'd1920, 14'd1080}, 0);
      send('{CMD_INTEGER, 14'd320, 14'd0, 14'd1920, 14'd1080}, 0);
      send('{CMD_INTEGER, 14'd320, 14'd240, 14'd1920, 14'd1080}, 0);
      send('{CMD_INTEGER, 14'd3000, 14'd240, 14'd1920, 14'd1080}, 0);
      send('{CMD_INTEGER, 14'd1, 14'd1, 14'd16383, 14'd16383}, 0);
      send('{CMD_ASPECT, 14'd16383, 14'd16383, 14'd0, 14'd0}, 0);
      send('{CMD_INTEGER, 14'd7, 14'd3, 14'd0, 14'd9}, 0);
      random_stall = 1;
      for (int i = 0; i < 800; i++) begin
         r.command = 2'($urandom_range(0, 3));
         r.src_width = rand_dim();
         r.src_height = rand_dim();
         r.dst_width = rand_dim();
         r.dst_height = rand_dim();
         if (i == 300) hold_off = 1;
         send(r, (i < 300 || i > 400));
      end
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.errors == 0)
         $display("[viewport_fit_calculator] OK");
      else
         $display("[viewport_fit_calculator] ERROR");
      $finish;
   end
endmodule
